// ===== src/rwpd_pkg.sv =====
`timescale 1ns / 1ps

package rwpd_pkg;

    localparam int unsigned PAYLOAD_DEPTH_DEF = 16;
    // at most this many payload bytes follow one status result
    localparam int unsigned RESULT_BYTES      = 16;

    localparam logic [7:0]  SYNC_RESET   = 8'hAA;
    localparam logic [4:0]  MAXLEN_RESET = 5'd16;
    localparam logic [15:0] WINDOW_RESET = 16'd120;

    localparam logic [7:0]  CRC_POLY = 8'h07;
    localparam logic [7:0]  CRC_INIT = 8'h00;
    localparam logic [7:0]  CRC_MSB  = 8'h80;

    // configuration register indexes
    localparam logic [1:0] CFG_SYNC   = 2'd0;
    localparam logic [1:0] CFG_MAXLEN = 2'd1;
    localparam logic [1:0] CFG_WINDOW = 2'd2;

    // deframer phase
    localparam logic [1:0] PH_SYNC    = 2'd0;
    localparam logic [1:0] PH_HEADER  = 2'd1;
    localparam logic [1:0] PH_PAYLOAD = 2'd2;

    // result status codes
    localparam logic [3:0] ST_ZERO     = 4'd0;
    localparam logic [3:0] ST_DEDUPE   = 4'd1;
    localparam logic [3:0] ST_NO_SYNC  = 4'd2;
    localparam logic [3:0] ST_SYNC_OK  = 4'd3;
    localparam logic [3:0] ST_BAD_LEN  = 4'd4;
    localparam logic [3:0] ST_HDR_OK   = 4'd5;
    localparam logic [3:0] ST_PARTIAL  = 4'd6;
    localparam logic [3:0] ST_CRC_OK   = 4'd7;
    localparam logic [3:0] ST_CRC_FAIL = 4'd8;

    typedef struct packed {
        logic [31:0] code_word;
        logic [31:0] time_ms;
    } in_t;

    typedef struct packed {
        logic [3:0] status;
        logic [7:0] seq_number;
        logic [7:0] packet_kind;
        logic [4:0] length_out;
        logic [7:0] crc_computed;
        logic [7:0] crc_received;
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       last_of_run;
    } out_t;

    function automatic int unsigned addr_bits(input int unsigned depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

    // one byte through the CRC-8, MSB first
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] din);
        logic [7:0] c;
        c = crc ^ din;
        for (int b = 0; b < 8; b++) begin
            if ((c & CRC_MSB) != 8'h00) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== src/rwpd_store.sv =====
`timescale 1ns / 1ps

module rwpd_store #(
    parameter int unsigned DEPTH = rwpd_pkg::PAYLOAD_DEPTH_DEF
) (
    input  logic                                   aclk,
    input  logic                                   wr_en,
    input  logic [rwpd_pkg::addr_bits(DEPTH)-1:0]  wr_addr,
    input  logic [7:0]                             wr_data,
    input  logic                                   rd_en,
    input  logic [rwpd_pkg::addr_bits(DEPTH)-1:0]  rd_addr,
    output logic [7:0]                             rd_data
);
    import rwpd_pkg::*;

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/rf_word_packet_deframer.sv =====
`timescale 1ns / 1ps
// Flow: an item taken in S_IDLE passes S_DECODE and S_POST before its first result is valid
// for a status-only item. A payload item also passes S_FILL to store bytes; completion runs
// the byte-wide CRC unit in S_CRC once per byte over seq, kind, length and payload, then
// each payload byte passes S_READ and S_LOAD after the previous result is taken.
// One item at a time: a new item is taken only once the last result of the item before is taken.
// Reset: aresetn synchronous, active low; control regs to defaults, phase to wait-for-sync.
module rf_word_packet_deframer #(
    parameter int unsigned PAYLOAD_DEPTH = rwpd_pkg::PAYLOAD_DEPTH_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    // input items
    input  logic            s_valid,
    output logic            s_ready,
    input  rwpd_pkg::in_t   s_data,
    // result items
    output logic            m_valid,
    input  logic            m_ready,
    output rwpd_pkg::out_t  m_data,
    // configuration writes
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [1:0]      cfg_index,
    input  logic [15:0]     cfg_data
);
    import rwpd_pkg::*;

    localparam int unsigned AW = addr_bits(PAYLOAD_DEPTH);
    // effective length cap from the store depth and the result budget
    localparam logic [4:0] LIMIT_CAP =
        5'((PAYLOAD_DEPTH < RESULT_BYTES) ? PAYLOAD_DEPTH : RESULT_BYTES);
    localparam logic [7:0] DEPTH_W = 8'(PAYLOAD_DEPTH);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_DECODE = 8'b0000_0010,
        S_FILL   = 8'b0000_0100,
        S_CRC    = 8'b0000_1000,
        S_POST   = 8'b0001_0000,
        S_RESULT = 8'b0010_0000,
        S_READ   = 8'b0100_0000,
        S_LOAD   = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [7:0]  sync_reg;
    logic [4:0]  maxlen_reg;
    logic [15:0] window_reg;

    // deframer state
    logic [1:0]  phase_reg;
    logic [7:0]  held_seq_reg;
    logic [7:0]  held_kind_reg;
    logic [4:0]  held_len_reg;
    logic [7:0]  held_crc_reg;
    logic [4:0]  fill_reg;
    logic [31:0] prev_code_reg;
    logic [31:0] prev_time_reg;

    // sequencer working registers
    in_t         in_reg;
    logic [3:0]  status_reg;
    logic [7:0]  crc_reg;
    logic [4:0]  idx_reg;    // CRC byte step, then emitted byte count
    logic [1:0]  j_reg;      // byte within the code word during fill
    out_t        out_reg;

    // store port
    logic          wr_en, rd_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [7:0]    wr_data, rd_data;

    logic [7:0]  b0, b1, b2;
    logic [4:0]  limit;
    logic [31:0] age;
    logic        is_dup;
    logic        fill_stop;
    logic [4:0]  fill_after;
    logic [7:0]  crc_in;
    logic [7:0]  crc_step;
    logic        crc_last;

    assign b0 = in_reg.code_word[23:16];
    assign b1 = in_reg.code_word[15:8];
    assign b2 = in_reg.code_word[7:0];

    assign limit  = (maxlen_reg < LIMIT_CAP) ? maxlen_reg : LIMIT_CAP;
    assign age    = in_reg.time_ms - prev_time_reg;
    assign is_dup = (in_reg.code_word == prev_code_reg) && (age < {16'h0000, window_reg});

    // fill: first byte always goes in, later ones only while short of the length
    assign fill_stop  = (j_reg != 2'd0) && (fill_reg >= held_len_reg);
    assign fill_after = fill_stop ? fill_reg : fill_reg + 5'd1;

    always_comb begin
        case (j_reg)
            2'd0:    wr_data = b0;
            2'd1:    wr_data = b1;
            default: wr_data = b2;
        endcase
    end
    assign wr_en   = (state_reg == S_FILL) && !fill_stop && ({3'b000, fill_reg} < DEPTH_W);
    assign wr_addr = AW'(fill_reg);

    // CRC order: seq, kind, length, then payload; store read runs one step ahead
    always_comb begin
        case (idx_reg)
            5'd0:    crc_in = held_seq_reg;
            5'd1:    crc_in = held_kind_reg;
            5'd2:    crc_in = {3'b000, held_len_reg};
            default: crc_in = rd_data;
        endcase
    end
    assign crc_step = crc8_byte(crc_reg, crc_in);
    assign crc_last = ({1'b0, idx_reg} == ({1'b0, held_len_reg} + 6'd2));

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = AW'(idx_reg);
        if (state_reg == S_CRC) begin
            rd_en   = (idx_reg >= 5'd2);
            rd_addr = AW'(idx_reg - 5'd2);
        end else if (state_reg == S_READ) begin
            rd_en   = 1'b1;
        end
    end

    rwpd_store #(
        .DEPTH (PAYLOAD_DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) state_next = S_DECODE;
            end
            S_DECODE: begin
                state_next = S_POST;
                if (in_reg.code_word != 32'h0 && !is_dup) begin
                    if (phase_reg == PH_HEADER) begin
                        if ({3'b000, limit} >= b0 && b0 == 8'h00) state_next = S_CRC;
                    end else if (phase_reg == PH_PAYLOAD) begin
                        state_next = S_FILL;
                    end
                end
            end
            S_FILL: begin
                if (fill_stop || j_reg == 2'd2) begin
                    state_next = (fill_after >= held_len_reg) ? S_CRC : S_POST;
                end
            end
            S_CRC: begin
                if (crc_last) state_next = S_POST;
            end
            S_POST: state_next = S_RESULT;
            S_RESULT: begin
                if (m_ready) state_next = out_reg.last_of_run ? S_IDLE : S_READ;
            end
            S_READ: state_next = S_LOAD;
            S_LOAD: state_next = S_RESULT;
            default: state_next = S_IDLE;
        endcase
    end

    // control and held state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            sync_reg      <= SYNC_RESET;
            maxlen_reg    <= MAXLEN_RESET;
            window_reg    <= WINDOW_RESET;
            phase_reg     <= PH_SYNC;
            held_seq_reg  <= 8'h00;
            held_kind_reg <= 8'h00;
            held_len_reg  <= 5'd0;
            held_crc_reg  <= 8'h00;
            fill_reg      <= 5'd0;
            prev_code_reg <= 32'h0;
            prev_time_reg <= 32'h0;
        end else begin
            state_reg <= state_next;

            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_SYNC:   sync_reg   <= cfg_data[7:0];
                    CFG_MAXLEN: maxlen_reg <= cfg_data[4:0];
                    CFG_WINDOW: window_reg <= cfg_data;
                    default: ;
                endcase
            end

            if (state_reg == S_DECODE && in_reg.code_word != 32'h0) begin
                prev_time_reg <= in_reg.time_ms;
                if (!is_dup) begin
                    prev_code_reg <= in_reg.code_word;
                    if (phase_reg == PH_HEADER) begin
                        if (b0 > {3'b000, limit}) begin
                            phase_reg <= PH_SYNC;
                        end else begin
                            held_len_reg <= b0[4:0];
                            held_crc_reg <= b1;
                            fill_reg     <= 5'd0;
                            if (b0 != 8'h00) phase_reg <= PH_PAYLOAD;
                        end
                    end else if (phase_reg != PH_PAYLOAD) begin
                        // wait-for-sync and the unused code
                        phase_reg <= PH_SYNC;
                        if (b0 == sync_reg) begin
                            held_seq_reg  <= b1;
                            held_kind_reg <= b2;
                            phase_reg     <= PH_HEADER;
                        end
                    end
                end
            end

            if (state_reg == S_FILL && !fill_stop) fill_reg <= fill_reg + 5'd1;
            if (state_reg == S_CRC && crc_last) phase_reg <= PH_SYNC;
        end
    end

    // datapath, no reset needed
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            S_IDLE: begin
                in_reg <= s_data;
            end
            S_DECODE: begin
                j_reg   <= 2'd0;
                idx_reg <= 5'd0;
                crc_reg <= CRC_INIT;
                if (in_reg.code_word == 32'h0) begin
                    status_reg <= ST_ZERO;
                end else if (is_dup) begin
                    status_reg <= ST_DEDUPE;
                end else if (phase_reg == PH_HEADER) begin
                    status_reg <= (b0 > {3'b000, limit}) ? ST_BAD_LEN : ST_HDR_OK;
                end else if (phase_reg == PH_PAYLOAD) begin
                    status_reg <= ST_PARTIAL;
                end else begin
                    status_reg <= (b0 == sync_reg) ? ST_SYNC_OK : ST_NO_SYNC;
                end
            end
            S_FILL: begin
                j_reg <= j_reg + 2'd1;
            end
            S_CRC: begin
                crc_reg <= crc_step;
                idx_reg <= idx_reg + 5'd1;
                if (crc_last) begin
                    status_reg <= (crc_step == held_crc_reg) ? ST_CRC_OK : ST_CRC_FAIL;
                end
            end
            S_POST: begin
                idx_reg              <= 5'd0;
                out_reg.status       <= status_reg;
                out_reg.seq_number   <= held_seq_reg;
                out_reg.packet_kind  <= held_kind_reg;
                out_reg.length_out   <= (status_reg == ST_PARTIAL) ? fill_reg : held_len_reg;
                out_reg.crc_computed <= (status_reg == ST_CRC_OK || status_reg == ST_CRC_FAIL)
                                        ? crc_reg : 8'h00;
                out_reg.crc_received <= held_crc_reg;
                out_reg.data_byte    <= 8'h00;
                out_reg.byte_valid   <= 1'b0;
                out_reg.last_of_run  <= !(status_reg == ST_CRC_OK && held_len_reg != 5'd0);
            end
            S_LOAD: begin
                idx_reg             <= idx_reg + 5'd1;
                out_reg.data_byte   <= rd_data;
                out_reg.byte_valid  <= 1'b1;
                out_reg.last_of_run <= (idx_reg + 5'd1 == held_len_reg);
            end
            default: ;
        endcase
    end

    assign s_ready   = (state_reg == S_IDLE);
    assign m_valid   = (state_reg == S_RESULT);
    assign m_data    = out_reg;
    assign cfg_ready = 1'b1;

endmodule
